/* rtl/lis_lts_pkg.sv */
`timescale 1ns / 1ps

package lis_lts_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 11;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  // length reported when the store has filled
  localparam int LEN_FULL = (MAX_LEN > LEN_MAX) ? LEN_MAX : MAX_LEN;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
  } out_t;

  // count clamped into the length field
  function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] cnt);
    logic [LEN_W-1:0] res;
    if (32'(cnt) > 32'(LEN_MAX)) begin
      res = LEN_W'(LEN_MAX);
    end else begin
      res = LEN_W'(cnt);
    end
    return res;
  endfunction

endpackage

/* rtl/lis_lts_ram.sv */
`timescale 1ns / 1ps

module lis_lts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lis_length_tails_search.sv */
`timescale 1ns / 1ps
// an appending item goes from idle straight to finish; a replacing item runs a binary
// search in the probe state, one tail read per probe cycle, and then goes to finish
// throughput: one item at a time, set by the binary search over the tail ram read port
// a last item's result lands in the output register when finish finds it free
// reset (rst, synchronous) clears count, overflow flag, sequencer and output valid;
// the tail ram is not cleared, only entries below the count are ever used

module lis_length_tails_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lis_lts_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lis_lts_pkg::out_t  out_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam int ADDR_W = lis_lts_pkg::ADDR_W;
  localparam int CNT_W  = lis_lts_pkg::CNT_W;
  localparam int SUM_W  = lis_lts_pkg::SUM_W;
  localparam int VAL_W  = lis_lts_pkg::VAL_W;

  // sequencer and sequence state
  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             overflow, overflow_next;

  // item being worked on
  logic signed [VAL_W-1:0] value, value_next;
  logic                    last, last_next;

  // cached copy of the top tail, so the append test needs no ram read
  logic signed [VAL_W-1:0] last_tail, last_tail_next;

  // search bounds
  logic [CNT_W-1:0]  lo, lo_next, hi, hi_next;
  logic [ADDR_W-1:0] mid, mid_next;

  // ram ports
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [VAL_W-1:0]  rdata;

  // output register
  logic               out_valid_next;
  lis_lts_pkg::out_t  out_data_next;

  logic               in_xfer;
  logic               out_free;
  logic               tail_less;
  logic [CNT_W-1:0]   probe_lo, probe_hi;
  logic [SUM_W-1:0]   bound_sum;
  logic [SUM_W-1:0]   count_ext;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // one probe: compare the tail just read, narrow the bounds, pick the next midpoint
  assign tail_less = $signed(rdata) < value;
  assign probe_lo  = tail_less ? CNT_W'({1'b0, mid} + SUM_W'(1)) : lo;
  assign probe_hi  = tail_less ? hi : CNT_W'(mid);
  assign bound_sum = {1'b0, probe_lo} + {1'b0, probe_hi};
  assign count_ext = {1'b0, count};

  lis_lts_ram #(
    .WIDTH (VAL_W),
    .DEPTH (lis_lts_pkg::MAX_LEN)
  ) u_tails (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    overflow_next  = overflow;
    value_next     = value;
    last_next      = last;
    last_tail_next = last_tail;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    we             = 1'b0;
    waddr          = ADDR_W'(count);
    raddr          = mid;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          value_next = in_data.value;
          last_next  = in_data.last;
          if ((count == '0) || (in_data.value > last_tail)) begin
            // append on top, or drop and flag when the store is full
            if (count == CNT_W'(lis_lts_pkg::MAX_LEN)) begin
              overflow_next = 1'b1;
            end else begin
              we             = 1'b1;
              waddr          = ADDR_W'(count);
              count_next     = count + CNT_W'(1);
              last_tail_next = in_data.value;
            end
            state_next = ST_FINISH;
          end else begin
            // replace: search [0, count) for the first tail not less than value
            lo_next    = '0;
            hi_next    = count;
            mid_next   = count_ext[ADDR_W:1];
            raddr      = count_ext[ADDR_W:1];
            state_next = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        lo_next  = probe_lo;
        hi_next  = probe_hi;
        mid_next = bound_sum[ADDR_W:1];
        raddr    = bound_sum[ADDR_W:1];
        if (probe_lo >= probe_hi) begin
          we    = 1'b1;
          waddr = ADDR_W'(probe_lo);
          if ((probe_lo + CNT_W'(1)) == count) begin
            last_tail_next = value;
          end
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!last) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next         = 1'b1;
          out_data_next.length   = lis_lts_pkg::sat_len(count);
          out_data_next.overflow = overflow;
          count_next             = '0;
          overflow_next          = 1'b0;
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      overflow  <= overflow_next;
      out_valid <= out_valid_next;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    value     <= value_next;
    last      <= last_next;
    last_tail <= last_tail_next;
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    out_data  <= out_data_next;
  end

endmodule

/* rtl/lis_lts_checker.sv */
`timescale 1ns / 1ps

module lis_lts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input lis_lts_pkg::in_t   in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lis_lts_pkg::out_t  out_data
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // the block is busy right after taking an item
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // a finished sequence always holds at least its last element
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.length != '0)
    else $error("zero length reported");

  // overflow only when the store was full
  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      out_data.length == lis_lts_pkg::LEN_W'(lis_lts_pkg::LEN_FULL))
    else $error("overflow flagged without a full store");

  // a waiting input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed or dropped while stalled");

endmodule

bind lis_length_tails_search lis_lts_checker u_lis_lts_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  // stimulus styles for the random short sequences
  typedef enum int unsigned {
    MODE_RANDOM,
    MODE_NARROW,
    MODE_WALK_UP,
    MODE_WALK_DOWN,
    MODE_CORNER
  } stim_mode_t;

  // tracks the smallest tails per length and queues the lengths still owed
  class tail_tracker_t;
    logic signed [lis_lts_pkg::VAL_W-1:0] tails [lis_lts_pkg::MAX_LEN];
    int unsigned                          used;
    bit                                   spilled;
    lis_lts_pkg::out_t                    expected_lengths [$];
    int unsigned                          mismatches;

    function new();
      used = 0;
      spilled = 1'b0;
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // apply one accepted input transfer to the tail store
    function void note_value(input lis_lts_pkg::in_t item);
      logic signed [lis_lts_pkg::VAL_W-1:0] v;
      int unsigned                          lo;
      int unsigned                          hi;
      int unsigned                          mid;
      lis_lts_pkg::out_t                    owed;
      v = item.value;
      if (used == 0 || v > tails[used-1]) begin
        // append, or note the spill when the store is already full
        if (used < lis_lts_pkg::MAX_LEN) begin
          tails[used] = v;
          used++;
        end else begin
          spilled = 1'b1;
        end
      end else begin
        // first tail not less than v
        lo = 0;
        hi = used;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tails[mid] < v) lo = mid + 1;
          else hi = mid;
        end
        if (lo < used) tails[lo] = v;
      end
      if (item.last) begin
        owed.length   = (used > lis_lts_pkg::LEN_MAX) ?
                        lis_lts_pkg::LEN_W'(lis_lts_pkg::LEN_MAX) :
                        lis_lts_pkg::LEN_W'(used);
        owed.overflow = spilled;
        expected_lengths = {expected_lengths, owed};
        used = 0;
        spilled = 1'b0;
      end
    endfunction

    task check_length(input lis_lts_pkg::out_t got);
      lis_lts_pkg::out_t want;
      if (expected_lengths.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: length %0d overflow %0d",
                                  got.length, got.overflow));
      end else begin
        want = expected_lengths.pop_front();
        if (got.length !== want.length)
          report_mismatch($sformatf("length %0d, predicted %0d", got.length, want.length));
        if (got.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %0d, predicted %0d",
                                    got.overflow, want.overflow));
      end
    endtask

    function int unsigned pending();
      return expected_lengths.size();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  lis_lts_pkg::in_t  in_data   = '0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  lis_lts_pkg::out_t out_data;

  // idle bursts enabled on both sides while set
  bit            idle_on = 1'b1;
  int unsigned   sent_items = 0;
  tail_tracker_t tracker = new();

  logic signed [lis_lts_pkg::VAL_W-1:0] corner_vals [5] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff, 32'sh0000_0001
  };

  lis_length_tails_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: check every output transfer against the oldest owed length
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_length(out_data);
  end

  // result side backpressure: random stall bursts while idling is enabled
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one input transfer, with an optional idle burst ahead of it
  // valid stays high across back-to-back items, no drop in between
  task automatic send_value(input logic signed [lis_lts_pkg::VAL_W-1:0] v,
                            input logic is_last);
    lis_lts_pkg::in_t item;
    item.value = v;
    item.last  = is_last;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_value(item);
    sent_items++;
  endtask

  // a short sequence in one of several styles, closed by a last item
  task automatic send_short_seq();
    int unsigned                          n;
    stim_mode_t                           mode;
    logic signed [lis_lts_pkg::VAL_W-1:0] v;
    logic signed [lis_lts_pkg::VAL_W-1:0] walk;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    mode = stim_mode_t'($urandom_range(0, 4));
    walk = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        MODE_RANDOM: v = $urandom;
        // tight range, lots of equal values
        MODE_NARROW: v = $signed($urandom_range(0, 8)) - 4;
        // mostly rising with small steps, repeats and dips
        MODE_WALK_UP: begin
          walk = walk + $urandom_range(0, 6) - 2;
          v = walk;
        end
        MODE_WALK_DOWN: begin
          walk = walk - $urandom_range(0, 3);
          v = walk;
        end
        default: v = corner_vals[$urandom_range(0, 4)];
      endcase
      send_value(v, i == n - 1);
    end
  endtask

  // strictly rising run of n_up values across the whole range, with a few
  // replacing items mixed in, then a closing last item
  task automatic send_rising_run(input int unsigned n_up, input int unsigned step,
                                 input logic signed [lis_lts_pkg::VAL_W-1:0] closing);
    logic signed [lis_lts_pkg::VAL_W-1:0] v;
    for (int unsigned i = 0; i < n_up; i++) begin
      v = 32'h8000_0000 + 32'(i) * 32'(step) + 32'($urandom_range(0, step - 1));
      send_value(v, 1'b0);
      // at or below the value just sent: a replacement, or a dropped append once the store is full
      if (i > 0 && $urandom_range(0, 15) == 0) send_value(v - $urandom_range(0, 1000), 1'b0);
    end
    send_value(closing, 1'b1);
  endtask

  initial begin
    int unsigned target;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: single items at both extremes
    send_value(32'sh8000_0000, 1'b1);
    send_value(32'sh7fff_ffff, 1'b1);
    // max first, then the minimum replaces it and zero appends
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh0000_0000, 1'b1);
    // equal values do not grow the length
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b1);
    // rising through the sign boundary
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'shffff_ffff, 1'b0);
    send_value(32'sh0000_0000, 1'b0);
    send_value(32'sh0000_0001, 1'b0);
    send_value(32'sh7fff_ffff, 1'b1);
    // a replacement of the first tail, then appends on the lowered tail
    send_value(32'sd3, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sd2, 1'b0);
    send_value(32'sd5, 1'b1);
    // falling run, length stays one
    send_value(32'sd10, 1'b0);
    send_value(32'sd9, 1'b0);
    send_value(32'sd8, 1'b0);
    send_value(32'sd7, 1'b1);

    // random short sequences, idling switched per sequence
    while (sent_items < 420) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_short_seq();
    end

    // appends past a full store, overflow flag expected
    idle_on = 1'b1;
    send_rising_run(lis_lts_pkg::MAX_LEN + 6, 4_000_000, 32'sh7fff_ffff);

    // last part with no idling on either side
    idle_on = 1'b0;
    target = sent_items + 150;
    while (sent_items < target) send_short_seq();
    in_valid <= 1'b0;

    // drain, then allow for the longest search latency
    while (tracker.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
